[hdl/ppc_pkg.sv]
// ----------------------------------------------------------------------------
// ppc_pkg
// shared types and constants of the permutation prefix crossover block
// ----------------------------------------------------------------------------
package ppc_pkg;

  localparam int unsigned CITY_W   = 6;
  localparam int unsigned ID_SPACE = 64;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned CFG_W    = 7;

  typedef logic [CITY_W-1:0] city_t;
  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [CFG_W-1:0]  cfg_t;

  // item function codes, code 3 is unused and ignored
  localparam func_t FUNC_LOAD_FIRST  = 2'd0;
  localparam func_t FUNC_LOAD_SECOND = 2'd1;
  localparam func_t FUNC_START       = 2'd2;

  localparam cfg_t CITY_COUNT_RST = 7'd64;
  localparam cfg_t MIN_CITIES     = 7'd2;

endpackage

[hdl/ppc_if.sv]
// ----------------------------------------------------------------------------
// ppc channel interfaces
// valid/ready channels for items, results and the configuration write
// ----------------------------------------------------------------------------
interface ppc_in_if;
  import ppc_pkg::*;
  logic  valid;
  logic  ready;
  func_t func;
  city_t city_id;
  city_t cut_point;

  modport source (output valid, output func, output city_id, output cut_point, input ready);
  modport sink   (input valid, input func, input city_id, input cut_point, output ready);
endinterface

interface ppc_out_if;
  import ppc_pkg::*;
  logic  valid;
  logic  ready;
  city_t child_city;
  logic  is_last;

  modport source (output valid, output child_city, output is_last, input ready);
  modport sink   (input valid, input child_city, input is_last, output ready);
endinterface

interface ppc_cfg_if;
  import ppc_pkg::*;
  logic valid;
  logic ready;
  cfg_t city_count;

  modport source (output valid, output city_count, input ready);
  modport sink   (input valid, input city_count, output ready);
endinterface

[hdl/ppc_ram.sv]
// ----------------------------------------------------------------------------
// ppc_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ppc_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                            clk_i,
  input  logic                                            we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr_i,
  input  logic [WIDTH-1:0]                                wdata_i,
  input  logic                                            re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr_i,
  output logic [WIDTH-1:0]                                rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds while no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/permutation_prefix_crossover_core.sv]
// ----------------------------------------------------------------------------
// permutation_prefix_crossover_core
// single-cut order crossover of two city tours held in on-chip parent stores
// ----------------------------------------------------------------------------
// Load items (func 0 / 1) append a city id to the first or second parent
// store, so loads stream in at one item per cycle while the block is idle.
// A start item (func 2) clamps its cut point and then walks the stores with
// one small sequencer: for every parent entry examined, S_READ presents the
// address to the parent ram and S_CHECK takes the registered read data, a
// second-parent city only if the seen bitmap does not hold it yet; the
// result side can stall the walk in S_CHECK and S_FLUSH while its output waits.
// The child tour leaves as one result item per city, the final one flagged
// with is_last; a start with nothing loaded gives no result. The input is
// not ready while a start is being worked on. The seen bitmap lives in
// flip-flops and is cleared in the cycle a start is taken, so there is no
// clearing pass after reset. The configuration port is always ready and is
// meant to be written only while the block is idle.
// ----------------------------------------------------------------------------
module permutation_prefix_crossover_core #(
  parameter int unsigned MAX_CITIES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ppc_in_if.sink     in_i,
  ppc_out_if.source  out_o,
  ppc_cfg_if.sink    cfg_i
);
  import ppc_pkg::*;

  // index width into a parent store and width of a count up to MAX_CITIES
  localparam int unsigned AW = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
  localparam int unsigned CW = $clog2(MAX_CITIES + 1);

  typedef logic [CW-1:0] cnt_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_FLUSH
  } state_e;

  state_e              state_q;
  cfg_t                city_count_q;
  cnt_t                first_fill_q;
  cnt_t                second_fill_q;
  cnt_t                tour_q;
  cnt_t                cut_q;
  cnt_t                f2_q;
  cnt_t                idx_q;
  cnt_t                emit_cnt_q;
  logic                phase_q;       // 0 first-parent prefix, 1 second-parent merge
  logic [ID_SPACE-1:0] seen_q;
  logic                held_valid_q;
  city_t               held_city_q;
  logic                out_valid_q;
  city_t               out_city_q;
  logic                out_last_q;

  // effective tour length from the register
  cnt_t  tour_len;
  cnt_t  f1_len;
  cnt_t  f2_len;
  cnt_t  cut_lim;
  cnt_t  cut_eff;
  logic  in_fire;
  logic  load_first;
  logic  load_second;
  logic  prefix_done;
  logic  merge_done;
  logic  rd_en;
  city_t first_rdata;
  city_t second_rdata;
  city_t rd_city;
  logic  take_city;
  logic  out_free;
  logic  out_load;

  always_comb begin
    if (city_count_q > CFG_W'(MAX_CITIES)) begin
      tour_len = CW'(MAX_CITIES);
    end else if (city_count_q < MIN_CITIES) begin
      tour_len = CW'(MIN_CITIES);
    end else begin
      tour_len = city_count_q[CW-1:0];
    end
  end

  // start clamps: the cut never passes tour length minus one or the first fill
  assign f1_len  = (first_fill_q < tour_len) ? first_fill_q : tour_len;
  assign f2_len  = (second_fill_q < tour_len) ? second_fill_q : tour_len;
  assign cut_lim = ((tour_len - CW'(1)) < f1_len) ? (tour_len - CW'(1)) : f1_len;
  assign cut_eff = (CFG_W'(in_i.cut_point) > CFG_W'(cut_lim)) ? cut_lim : CW'(in_i.cut_point);

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign load_first  = in_fire && (in_i.func == FUNC_LOAD_FIRST) && (first_fill_q < tour_len);
  assign load_second = in_fire && (in_i.func == FUNC_LOAD_SECOND) && (second_fill_q < tour_len);

  // loop ends: index reached its bound or the child is complete
  assign prefix_done = (idx_q == cut_q) || (emit_cnt_q == tour_q);
  assign merge_done  = (idx_q == f2_q) || (emit_cnt_q == tour_q);
  assign rd_en       = (state_q == S_READ) && !(phase_q ? merge_done : prefix_done);

  ppc_ram #(
    .WIDTH (CITY_W),
    .DEPTH (MAX_CITIES)
  ) u_first_ram (
    .clk_i   (clk_i),
    .we_i    (load_first),
    .waddr_i (first_fill_q[AW-1:0]),
    .wdata_i (in_i.city_id),
    .re_i    (rd_en && !phase_q),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (first_rdata)
  );

  ppc_ram #(
    .WIDTH (CITY_W),
    .DEPTH (MAX_CITIES)
  ) u_second_ram (
    .clk_i   (clk_i),
    .we_i    (load_second),
    .waddr_i (second_fill_q[AW-1:0]),
    .wdata_i (in_i.city_id),
    .re_i    (rd_en && phase_q),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (second_rdata)
  );

  // prefix cities are always taken, merge cities only when not yet seen
  assign rd_city   = phase_q ? second_rdata : first_rdata;
  assign take_city = !phase_q || !seen_q[rd_city];
  assign out_free  = !out_valid_q || out_o.ready;

  // the held city moves to the output register when a new one is taken or at the flush
  assign out_load  = held_valid_q && out_free &&
                     (((state_q == S_CHECK) && take_city) || (state_q == S_FLUSH));

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      city_count_q  <= CITY_COUNT_RST;
      first_fill_q  <= '0;
      second_fill_q <= '0;
      tour_q        <= '0;
      cut_q         <= '0;
      f2_q          <= '0;
      idx_q         <= '0;
      emit_cnt_q    <= '0;
      phase_q       <= 1'b0;
      seen_q        <= '0;
      held_valid_q  <= 1'b0;
      held_city_q   <= '0;
      out_valid_q   <= 1'b0;
      out_city_q    <= '0;
      out_last_q    <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        city_count_q <= cfg_i.city_count;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (load_first) begin
            first_fill_q <= first_fill_q + CW'(1);
          end
          if (load_second) begin
            second_fill_q <= second_fill_q + CW'(1);
          end
          if (in_fire && (in_i.func == FUNC_START)) begin
            tour_q       <= tour_len;
            cut_q        <= cut_eff;
            f2_q         <= f2_len;
            idx_q        <= '0;
            emit_cnt_q   <= '0;
            phase_q      <= 1'b0;
            seen_q       <= '0;
            held_valid_q <= 1'b0;
            state_q      <= S_READ;
          end
        end

        S_READ: begin
          if (!phase_q && prefix_done) begin
            phase_q <= 1'b1;
            idx_q   <= '0;
          end else if (phase_q && merge_done) begin
            state_q <= S_FLUSH;
          end else begin
            state_q <= S_CHECK;
          end
        end

        S_CHECK: begin
          if (!take_city) begin
            idx_q   <= idx_q + CW'(1);
            state_q <= S_READ;
          end else if (!held_valid_q || out_free) begin
            // the held city is not the last one, pass it on
            if (held_valid_q) begin
              out_city_q  <= held_city_q;
              out_last_q  <= 1'b0;
            end
            held_valid_q    <= 1'b1;
            held_city_q     <= rd_city;
            seen_q[rd_city] <= 1'b1;
            emit_cnt_q      <= emit_cnt_q + CW'(1);
            idx_q           <= idx_q + CW'(1);
            state_q         <= S_READ;
          end
        end

        S_FLUSH: begin
          if (!held_valid_q || out_free) begin
            if (held_valid_q) begin
              out_city_q  <= held_city_q;
              out_last_q  <= 1'b1;
            end
            held_valid_q  <= 1'b0;
            first_fill_q  <= '0;
            second_fill_q <= '0;
            state_q       <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.child_city = out_city_q;
  assign out_o.is_last    = out_last_q;

  // child never grows past the tour length
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (emit_cnt_q <= tour_q))
    else $error("child longer than tour");

  // a city taken in the check step is marked seen afterwards
  a_seen_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK && take_city && (!held_valid_q || out_free))
      |=> seen_q[$past(rd_city)])
    else $error("taken city not marked seen");

  // fill counts stay inside the parent stores
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (first_fill_q <= CW'(MAX_CITIES)) && (second_fill_q <= CW'(MAX_CITIES)))
    else $error("parent fill count out of range");

  // a flush with nothing held ends the start at once with empty parents
  a_empty_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH && !held_valid_q)
      |=> (state_q == S_IDLE && first_fill_q == '0 && second_fill_q == '0))
    else $error("flush did not return to idle");

endmodule
